FILE: hdl/npp_pkg.sv
// Shared types, constants and helper functions for the NMEA position parser.
package npp_pkg;

   // Sentence framing limits.
   localparam int          MAX_SENTENCE_BYTES = 101;
   localparam logic [6:0]  BYTE_POS_MAX       = 7'd127;
   localparam logic [6:0]  BYTE_POS_LIMIT     = 7'(MAX_SENTENCE_BYTES);
   localparam logic [6:0]  POS_KIND_FIRST     = 7'd3;
   localparam logic [6:0]  POS_KIND_SECOND    = 7'd4;
   localparam logic [6:0]  POS_KIND_THIRD     = 7'd5;
   localparam logic [4:0]  FIELD_INDEX_MAX    = 5'd31;
   localparam logic [3:0]  FIELD_CHARS_MAX    = 4'd15;

   // Field numbers inside a sentence.
   localparam logic [4:0]  FIELD_TIME     = 5'd1;
   localparam logic [4:0]  FIELD_LAT      = 5'd2;
   localparam logic [4:0]  FIELD_LAT_HEMI = 5'd3;
   localparam logic [4:0]  FIELD_LON      = 5'd4;
   localparam logic [4:0]  FIELD_LON_HEMI = 5'd5;
   localparam logic [4:0]  FIELD_QUALITY  = 5'd6;
   localparam logic [4:0]  FIELD_SATS     = 5'd7;
   localparam logic [4:0]  FIELD_ALT      = 5'd9;

   // ASCII codes.
   localparam logic [7:0]  CHAR_STAR  = 8'h2A;
   localparam logic [7:0]  CHAR_COMMA = 8'h2C;
   localparam logic [7:0]  CHAR_MINUS = 8'h2D;
   localparam logic [7:0]  CHAR_POINT = 8'h2E;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;
   localparam logic [7:0]  CHAR_A     = 8'h41;
   localparam logic [7:0]  CHAR_G     = 8'h47;
   localparam logic [7:0]  CHAR_N     = 8'h4E;
   localparam logic [7:0]  CHAR_S     = 8'h53;
   localparam logic [7:0]  CHAR_T     = 8'h54;
   localparam logic [7:0]  CHAR_W     = 8'h57;

   // Number accumulation limits and result caps.
   localparam logic [23:0] WHOLE_CAP  = 24'd9999999;
   localparam logic [2:0]  FRAC_MAX   = 3'd5;
   localparam logic [23:0] TIME_CAP   = 24'd999999;
   localparam logic [23:0] QUAL_CAP   = 24'd9;
   localparam logic [23:0] SATS_CAP   = 24'd99;
   localparam logic [27:0] ALT_CAP    = 28'd999999;
   localparam logic [31:0] LAT_CAP    = 32'd999999999;
   localparam logic [31:0] LON_CAP    = 32'd1999999999;

   // Angle conversion constants: reciprocal multipliers for /100 and /3.
   localparam logic [24:0] DIV100_MUL   = 25'd21474837;
   localparam int          DIV100_SHIFT = 31;
   localparam logic [25:0] DIV3_MUL     = 26'd44739243;
   localparam int          DIV3_SHIFT   = 27;
   localparam logic [39:0] DEG_SCALE    = 40'd10000000;
   localparam logic [25:0] MIN_SCALE_X5 = 26'd500000;
   localparam logic [25:0] FRAC_X5      = 26'd5;
   localparam int          ANG_STAGES   = 5;

   typedef enum logic [1:0] {
      KIND_GGA  = 2'd0,
      KIND_GNS  = 2'd1,
      KIND_GST  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   // Raw latitude or longitude as parsed, before conversion to 1e-7 degrees.
   typedef struct packed {
      logic [23:0] whole;
      logic [16:0] frac;
      logic [2:0]  digits;
      logic        present;
      logic        negative;
   } angle_raw_type;

   // Result fields that need no further arithmetic.
   typedef struct packed {
      kind_type           kind;
      logic               pos_valid;
      logic signed [20:0] altitude;
      logic [19:0]        utc_hhmmss;
      logic [6:0]         hundredths;
      logic [3:0]         quality;
      logic [6:0]         sats;
   } result_type;

   // Everything the scanner hands to the conversion pipeline.
   typedef struct packed {
      result_type    info;
      angle_raw_type lat;
      angle_raw_type lon;
   } snap_type;

   // Scale factor that brings a fraction with the given digit count to five digits.
   function automatic logic [16:0] pow10_e5(input logic [2:0] digits);
      logic [16:0] scale;
      case (digits)
         3'd0:    scale = 17'd100000;
         3'd1:    scale = 17'd10000;
         3'd2:    scale = 17'd1000;
         3'd3:    scale = 17'd100;
         3'd4:    scale = 17'd10;
         default: scale = 17'd1;
      endcase
      return scale;
   endfunction

   // Third letter of the sentence type that a candidate kind expects.
   function automatic logic [7:0] kind_third(input kind_type kind);
      logic [7:0] letter;
      case (kind)
         KIND_GGA: letter = CHAR_A;
         KIND_GNS: letter = CHAR_S;
         KIND_GST: letter = CHAR_T;
         default:  letter = 8'h00;
      endcase
      return letter;
   endfunction

endpackage

FILE: hdl/npp_scan.sv
// Byte scanner: sentence kind detection, field splitting and number accumulation.
module npp_scan import npp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     byte_valid,
   input  logic     byte_accept,
   input  logic [7:0] char_in,
   input  logic     first_byte,
   input  logic     last_byte,
   input  logic     snap_take,
   output logic     byte_ready,
   output logic     snap_valid,
   output snap_type snap_data
);

   // State of the field being read.
   typedef struct packed {
      logic [3:0]  chars;
      logic [23:0] whole;
      logic [16:0] frac;
      logic [2:0]  digits;
      logic        seen_point;
      logic        minus;
      logic [3:0]  frac_a;
      logic [3:0]  frac_b;
   } field_type;

   // Values collected from closed fields of the current sentence.
   typedef struct packed {
      angle_raw_type      lat;
      angle_raw_type      lon;
      logic [19:0]        utc_hhmmss;
      logic [6:0]         hundredths;
      logic [3:0]         quality;
      logic [6:0]         sats;
      logic signed [20:0] altitude;
   } sent_type;

   localparam field_type FIELD_CLEAR = '0;
   localparam sent_type  SENT_CLEAR  = '0;

   kind_type  kind_ff, kind_in, cand_ff, cand_in;
   logic [6:0] pos_ff, pos_in;
   logic [4:0] index_ff, index_in;
   field_type fld_ff, fld_in;
   sent_type  sent_ff, sent_in;
   logic      done_ff, done_in;
   logic      snap_valid_ff, snap_valid_in;
   snap_type  snap_ff, snap_in;

   kind_type   kind_s, cand_s, kind_d, cand_d;
   logic [6:0] pos_s;
   logic [4:0] index_s, index_next;
   field_type  fld_s, fld_a;
   sent_type   sent_s, sent_a, sent_1, sent_2;
   logic       active, parse, is_star, is_comma, is_digit;
   logic       close_a, close_b, finish, emit;
   logic [7:0] digit_full;
   logic [3:0] digit;
   logic [27:0] whole_wide;

   // Apply the closing of one field to the sentence record.
   function automatic sent_type close_fld(input sent_type s, input kind_type k,
                                          input logic [4:0] fi, input field_type f);
      sent_type    r;
      logic        present;
      logic [27:0] dm;
      logic [19:0] dm_sat;
      logic [20:0] alt_mag;
      r       = s;
      present = (f.chars != 4'd0);
      dm      = {4'b0, f.whole} * 28'd10 + {24'b0, f.frac_a};
      dm_sat  = (dm > ALT_CAP) ? ALT_CAP[19:0] : dm[19:0];
      alt_mag = {1'b0, dm_sat};
      if (k != KIND_NONE) begin
         if (fi == FIELD_TIME) begin
            r.utc_hhmmss = (f.whole > TIME_CAP) ? TIME_CAP[19:0] : f.whole[19:0];
            r.hundredths = {3'b0, f.frac_a} * 7'd10 + {3'b0, f.frac_b};
         end else if (k != KIND_GST) begin
            if (fi == FIELD_LAT) begin
               r.lat.whole   = f.whole;
               r.lat.frac    = f.frac;
               r.lat.digits  = f.digits;
               r.lat.present = present;
            end else if (fi == FIELD_LON) begin
               r.lon.whole   = f.whole;
               r.lon.frac    = f.frac;
               r.lon.digits  = f.digits;
               r.lon.present = present;
            end else if (fi == FIELD_QUALITY && k == KIND_GGA) begin
               r.quality = (f.whole > QUAL_CAP) ? QUAL_CAP[3:0] : f.whole[3:0];
            end else if (fi == FIELD_SATS) begin
               r.sats = (f.whole > SATS_CAP) ? SATS_CAP[6:0] : f.whole[6:0];
            end else if (fi == FIELD_ALT) begin
               r.altitude = f.minus ? -alt_mag : alt_mag;
            end
         end
      end
      return r;
   endfunction

   // The scanner stalls only while its snapshot is still waiting to move on.
   assign byte_ready = !snap_valid_ff || snap_take;
   assign snap_valid = snap_valid_ff;
   assign snap_data  = snap_ff;

   // Next state for one accepted byte.
   always_comb begin
      kind_s  = kind_ff;
      cand_s  = cand_ff;
      pos_s   = pos_ff;
      index_s = index_ff;
      fld_s   = fld_ff;
      sent_s  = sent_ff;
      if (first_byte) begin
         kind_s  = KIND_NONE;
         cand_s  = KIND_NONE;
         pos_s   = 7'd0;
         index_s = 5'd0;
         fld_s   = FIELD_CLEAR;
         sent_s  = SENT_CLEAR;
      end
      active     = first_byte || !done_ff;
      parse      = (pos_s < BYTE_POS_LIMIT);
      is_star    = (char_in == CHAR_STAR);
      is_comma   = (char_in == CHAR_COMMA);
      is_digit   = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
      digit_full = char_in - CHAR_ZERO;
      digit      = digit_full[3:0];
      whole_wide = {4'b0, fld_s.whole} * 28'd10 + {24'b0, digit};

      // Sentence type from bytes three to five.
      kind_d = kind_s;
      cand_d = cand_s;
      if (parse) begin
         if (pos_s == POS_KIND_FIRST) begin
            if (char_in == CHAR_G) cand_d = KIND_GGA;
            else                   cand_d = KIND_NONE;
         end else if (pos_s == POS_KIND_SECOND && cand_s == KIND_GGA) begin
            if (char_in == CHAR_G)      cand_d = KIND_GGA;
            else if (char_in == CHAR_N) cand_d = KIND_GNS;
            else if (char_in == CHAR_S) cand_d = KIND_GST;
            else                        cand_d = KIND_NONE;
         end else if (pos_s == POS_KIND_THIRD && cand_s != KIND_NONE) begin
            if (char_in == kind_third(cand_s)) kind_d = cand_s;
         end
      end

      // Characters inside a field.
      fld_a  = fld_s;
      sent_a = sent_s;
      if (parse && !is_star && !is_comma) begin
         if (is_digit) begin
            if (!fld_s.seen_point) begin
               fld_a.whole = (whole_wide > {4'b0, WHOLE_CAP}) ? WHOLE_CAP : whole_wide[23:0];
            end else if (fld_s.digits < FRAC_MAX) begin
               fld_a.frac   = fld_s.frac * 17'd10 + {13'b0, digit};
               fld_a.digits = fld_s.digits + 3'd1;
               if (fld_s.digits == 3'd0) fld_a.frac_a = digit;
               if (fld_s.digits == 3'd1) fld_a.frac_b = digit;
            end
         end else if (char_in == CHAR_POINT) begin
            fld_a.seen_point = 1'b1;
         end else if (char_in == CHAR_MINUS && fld_s.chars == 4'd0) begin
            fld_a.minus = 1'b1;
         end
         if (index_s == FIELD_LAT_HEMI && char_in == CHAR_S) sent_a.lat.negative = 1'b1;
         if (index_s == FIELD_LON_HEMI && char_in == CHAR_W) sent_a.lon.negative = 1'b1;
         if (fld_s.chars != FIELD_CHARS_MAX) fld_a.chars = fld_s.chars + 4'd1;
      end

      // A comma on the last byte closes the field it ends and an empty one after it.
      close_a    = active && ((parse && (is_star || is_comma)) || last_byte);
      close_b    = active && parse && is_comma && last_byte;
      finish     = active && ((parse && is_star) || last_byte);
      emit       = finish && (kind_d != KIND_NONE);
      index_next = (index_s == FIELD_INDEX_MAX) ? index_s : index_s + 5'd1;
      sent_1     = close_a ? close_fld(sent_a, kind_d, index_s, fld_a) : sent_a;
      sent_2     = close_b ? close_fld(sent_1, kind_d, index_next, FIELD_CLEAR) : sent_1;

      kind_in  = kind_ff;
      cand_in  = cand_ff;
      pos_in   = pos_ff;
      index_in = index_ff;
      fld_in   = fld_ff;
      sent_in  = sent_ff;
      done_in  = done_ff;
      if (active) begin
         kind_in  = kind_d;
         cand_in  = cand_d;
         pos_in   = (pos_s == BYTE_POS_MAX) ? pos_s : pos_s + 7'd1;
         index_in = close_a ? index_next : index_s;
         fld_in   = close_a ? FIELD_CLEAR : fld_a;
         sent_in  = sent_2;
         done_in  = finish;
      end

      // Snapshot for the conversion pipeline.
      snap_in.info.kind       = kind_d;
      snap_in.info.pos_valid  = sent_2.lat.present && sent_2.lon.present &&
                                (kind_d != KIND_GST);
      snap_in.info.altitude   = sent_2.altitude;
      snap_in.info.utc_hhmmss = sent_2.utc_hhmmss;
      snap_in.info.hundredths = sent_2.hundredths;
      snap_in.info.quality    = sent_2.quality;
      snap_in.info.sats       = sent_2.sats;
      snap_in.lat             = sent_2.lat;
      snap_in.lon             = sent_2.lon;

      if (byte_accept && emit)  snap_valid_in = 1'b1;
      else if (snap_take)       snap_valid_in = 1'b0;
      else                      snap_valid_in = snap_valid_ff;
   end

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= KIND_NONE;
         cand_ff       <= KIND_NONE;
         pos_ff        <= 7'd0;
         index_ff      <= 5'd0;
         fld_ff        <= FIELD_CLEAR;
         sent_ff       <= SENT_CLEAR;
         done_ff       <= 1'b1;
         snap_valid_ff <= 1'b0;
      end else begin
         if (byte_accept) begin
            kind_ff  <= kind_in;
            cand_ff  <= cand_in;
            pos_ff   <= pos_in;
            index_ff <= index_in;
            fld_ff   <= fld_in;
            sent_ff  <= sent_in;
            done_ff  <= done_in;
         end
         snap_valid_ff <= snap_valid_in;
      end
   end

   // Snapshot payload.
   always_ff @(posedge clock) begin
      if (byte_valid && byte_accept && emit) begin
         snap_ff <= snap_in;
      end
   end

endmodule

FILE: hdl/npp_angle.sv
// Five-stage conversion of a raw ddmm.mmmmm angle into signed 1e-7 degrees.
module npp_angle import npp_pkg::*; (
   input  logic                  clock,
   input  logic [ANG_STAGES-1:0] stage_en,
   input  angle_raw_type         raw,
   input  logic [31:0]           cap,
   output logic [31:0]           angle
);

   logic [23:0] whole_1_ff;
   logic [16:0] deg_1_ff, fe5_1_ff;
   logic        pres_1_ff, neg_1_ff;
   logic [6:0]  mins_2_ff;
   logic [39:0] deg_e7_2_ff, deg_e7_3_ff, deg_e7_4_ff;
   logic [16:0] fe5_2_ff;
   logic        pres_2_ff, neg_2_ff, pres_3_ff, neg_3_ff, pres_4_ff, neg_4_ff;
   logic [25:0] x_3_ff;
   logic [23:0] q_4_ff;
   logic [31:0] angle_5_ff, angle_5_in;

   logic [48:0] prod_div100;
   logic [33:0] prod_frac;
   logic [23:0] deg_x100, rem;
   logic [39:0] deg_e7;
   logic [25:0] x_sum;
   logic [51:0] prod_div3;
   logic [39:0] total;
   logic [31:0] sat;

   // Stage one: degrees by reciprocal multiply, fraction scaled to five digits.
   assign prod_div100 = raw.whole * DIV100_MUL;
   assign prod_frac   = raw.frac * pow10_e5(raw.digits);
   // Stage two: minutes remainder and degrees times ten million.
   assign deg_x100    = deg_1_ff * 24'd100;
   assign rem         = whole_1_ff - deg_x100;
   assign deg_e7      = deg_1_ff * DEG_SCALE;
   // Stage three: five times minutes_e5.
   assign x_sum       = mins_2_ff * MIN_SCALE_X5 + fe5_2_ff * FRAC_X5;
   // Stage four: divide by three through a reciprocal.
   assign prod_div3   = x_3_ff * DIV3_MUL;
   // Stage five: sum, saturate and apply the hemisphere sign.
   assign total       = deg_e7_4_ff + {16'b0, q_4_ff};
   assign sat         = (total > {8'b0, cap}) ? cap : total[31:0];

   always_comb begin
      if (!pres_4_ff)    angle_5_in = 32'd0;
      else if (neg_4_ff) angle_5_in = -sat;
      else               angle_5_in = sat;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         whole_1_ff <= raw.whole;
         deg_1_ff   <= prod_div100[DIV100_SHIFT +: 17];
         fe5_1_ff   <= prod_frac[16:0];
         pres_1_ff  <= raw.present;
         neg_1_ff   <= raw.negative;
      end
      if (stage_en[1]) begin
         mins_2_ff   <= rem[6:0];
         deg_e7_2_ff <= deg_e7;
         fe5_2_ff    <= fe5_1_ff;
         pres_2_ff   <= pres_1_ff;
         neg_2_ff    <= neg_1_ff;
      end
      if (stage_en[2]) begin
         x_3_ff      <= x_sum;
         deg_e7_3_ff <= deg_e7_2_ff;
         pres_3_ff   <= pres_2_ff;
         neg_3_ff    <= neg_2_ff;
      end
      if (stage_en[3]) begin
         q_4_ff      <= prod_div3[DIV3_SHIFT +: 24];
         deg_e7_4_ff <= deg_e7_3_ff;
         pres_4_ff   <= pres_3_ff;
         neg_4_ff    <= neg_3_ff;
      end
      if (stage_en[4]) begin
         angle_5_ff <= angle_5_in;
      end
   end

   assign angle = angle_5_ff;

endmodule

FILE: hdl/nmea_position_parser.sv
// Top level of the NMEA position parser: scanner, angle pipelines and result stage.
//
//  Channel  Direction  Handshake                 Payload
//  req      in         req_tvalid / req_tready   tdata: char; tuser: first byte; tlast: last byte
//  rsp      out        rsp_tvalid / rsp_tready   tdata: position, altitude, time, fix; tuser: kind
//
// One byte is taken per clock cycle while req_tready is high; the scanner updates its field state
// in that cycle. A result word moves from the snapshot register through the angle pipeline stages
// in order: divide by 100, minutes and degree scale, times five, divide by 3, sum and saturate.
// Reset is synchronous and active high; afterwards bytes are ignored until a first byte.
// Pipeline stages move whenever the stage after them is empty or moving, so req_tready
// drops only when the snapshot and every stage hold a result and rsp_tready is low.
module nmea_position_parser import npp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // [7:0] char_in
   input  logic         req_tuser,  // [0] first_byte
   input  logic         req_tlast,  // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // [30:0] latitude_e7, [62:31] longitude_e7,
                                    // [63] position_valid, [84:64] altitude_dm,
                                    // [104:85] time_hhmmss, [111:105] time_hundredths,
                                    // [115:112] fix_quality, [122:116] satellites, zeros
   output logic [1:0]   rsp_tuser   // [1:0] sentence_kind
);

   logic                  byte_accept, snap_valid;
   snap_type              snap_data;
   logic [ANG_STAGES-1:0] adv, valid_ff, valid_in, valid_prev;
   result_type            info_ff [ANG_STAGES];
   result_type            info_prev [ANG_STAGES];
   result_type            info_out;
   logic [31:0]           lat_angle, lon_angle;
   logic                  nxt;

   assign byte_accept = req_tvalid && req_tready;

   npp_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_accept (byte_accept),
      .char_in     (req_tdata),
      .first_byte  (req_tuser),
      .last_byte   (req_tlast),
      .snap_take   (adv[0]),
      .byte_ready  (req_tready),
      .snap_valid  (snap_valid),
      .snap_data   (snap_data)
   );

   npp_angle u_lat (
      .clock    (clock),
      .stage_en (adv),
      .raw      (snap_data.lat),
      .cap      (LAT_CAP),
      .angle    (lat_angle)
   );

   npp_angle u_lon (
      .clock    (clock),
      .stage_en (adv),
      .raw      (snap_data.lon),
      .cap      (LON_CAP),
      .angle    (lon_angle)
   );

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      nxt = rsp_tready;
      for (int k = ANG_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || nxt;
         nxt    = adv[k];
      end
      valid_prev = {valid_ff[ANG_STAGES-2:0], snap_valid};
      for (int k = 0; k < ANG_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_prev[k] : valid_ff[k];
      end
      info_prev[0] = snap_data.info;
      for (int k = 1; k < ANG_STAGES; k++) begin
         info_prev[k] = info_ff[k-1];
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Fields that ride alongside the angle conversion.
   always_ff @(posedge clock) begin
      for (int k = 0; k < ANG_STAGES; k++) begin
         if (adv[k]) info_ff[k] <= info_prev[k];
      end
   end

   // Result word.
   assign info_out   = info_ff[ANG_STAGES-1];
   assign rsp_tvalid = valid_ff[ANG_STAGES-1];
   assign rsp_tuser  = info_out.kind;
   assign rsp_tdata  = {5'b0, info_out.sats, info_out.quality, info_out.hundredths,
                        info_out.utc_hhmmss, info_out.altitude, info_out.pos_valid,
                        lon_angle, lat_angle[30:0]};

`ifndef ASSERT_OFF
   // Sentences of unknown kind never reach the output.
   a_known_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != KIND_NONE))
      else $error("result word carries an unknown sentence kind");

   // A GST result carries no position.
   a_gst_no_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_GST) |-> (rsp_tdata[63:0] == 64'd0))
      else $error("GST result carries position data");

   // Input stalls when the snapshot and every stage are full and the output waits.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (snap_valid && (&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("byte accepted while the pipeline is full");

   // A held result stays valid on the next cycle while stalled.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ANG_STAGES-1] && !rsp_tready) |=> valid_ff[ANG_STAGES-1])
      else $error("output stage lost a result while stalled");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the NMEA position parser: stimulus, predictor and result checks.
module testbench;
   import npp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Expected content of one result word.
   typedef struct packed {
      kind_type           kind;
      logic signed [30:0] lat;
      logic signed [31:0] lon;
      logic               pos_valid;
      logic signed [20:0] alt;
      logic [19:0]        hhmmss;
      logic [6:0]         hund;
      logic [3:0]         quality;
      logic [6:0]         sats;
   } fix_report_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;  // [7:0] char_in
   logic         req_tuser  = 1'b0;   // [0] first_byte
   logic         req_tlast  = 1'b0;   // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;           // [30:0] latitude_e7, [62:31] longitude_e7,
                                      // [63] position_valid, [84:64] altitude_dm,
                                      // [104:85] time_hhmmss, [111:105] time_hundredths,
                                      // [115:112] fix_quality, [122:116] satellites
   logic [1:0]   rsp_tuser;           // [1:0] sentence_kind

   fix_report_type fix_reports[$];
   byte unsigned line_buf[$];
   int           error_count     = 0;
   int           bytes_sent      = 0;
   bit           tx_idle_on      = 1'b0;
   bit           rx_idle_on      = 1'b0;
   int           rx_hold_request = 0;
   int           rx_wait_left    = 0;

   // Predictor state.
   kind_type     fix_kind, cand_kind;
   logic [6:0]   byte_pos;
   logic [4:0]   field_no;
   logic [3:0]   field_chars;
   int unsigned  whole_acc, frac_acc, frac_cnt;
   bit           point_seen, minus_seen, parser_idle;
   int           lat_mag, lon_mag, alt_dm;
   bit           south_seen, west_seen, lat_given, lon_given;
   int unsigned  utc_time, utc_hund, fix_quality, sat_count;

   nmea_position_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned ten_pow(input int unsigned n);
      longint unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   function automatic void nmea_clear_field();
      field_chars = '0;
      whole_acc   = 0;
      frac_acc    = 0;
      frac_cnt    = 0;
      point_seen  = 1'b0;
      minus_seen  = 1'b0;
   endfunction

   function automatic void nmea_clear_sentence();
      fix_kind  = KIND_NONE;
      cand_kind = KIND_NONE;
      byte_pos  = '0;
      field_no  = '0;
      nmea_clear_field();
      lat_mag     = 0;
      lon_mag     = 0;
      alt_dm      = 0;
      south_seen  = 1'b0;
      west_seen   = 1'b0;
      lat_given   = 1'b0;
      lon_given   = 1'b0;
      utc_time    = 0;
      utc_hund    = 0;
      fix_quality = 0;
      sat_count   = 0;
   endfunction

   // Degrees and minutes of the current field in 1e-7 degrees, capped.
   function automatic int nmea_angle_e7(input longint unsigned cap);
      longint unsigned deg, mins, me5, v;
      deg  = whole_acc / 100;
      mins = whole_acc % 100;
      me5  = mins * 100000 + longint'(frac_acc) * ten_pow(5 - frac_cnt);
      v    = deg * 10000000 + me5 * 5 / 3;
      if (v > cap) v = cap;
      return int'(v);
   endfunction

   function automatic void nmea_close_field();
      bit              present;
      longint unsigned dm;
      present = field_chars != 0;
      if (fix_kind != KIND_NONE) begin
         if (field_no == FIELD_TIME) begin
            utc_time = (whole_acc > 999999) ? 999999 : whole_acc;
            if (frac_cnt == 0) utc_hund = 0;
            else if (frac_cnt == 1) utc_hund = frac_acc * 10;
            else utc_hund = 32'(frac_acc / ten_pow(frac_cnt - 2));
         end else if (fix_kind != KIND_GST) begin
            if (field_no == FIELD_LAT) begin
               lat_mag   = present ? nmea_angle_e7(999999999) : 0;
               lat_given = present;
            end else if (field_no == FIELD_LON) begin
               lon_mag   = present ? nmea_angle_e7(1999999999) : 0;
               lon_given = present;
            end else if (field_no == FIELD_QUALITY && fix_kind == KIND_GGA) begin
               fix_quality = (whole_acc > 9) ? 9 : whole_acc;
            end else if (field_no == FIELD_SATS) begin
               sat_count = (whole_acc > 99) ? 99 : whole_acc;
            end else if (field_no == FIELD_ALT) begin
               dm = longint'(whole_acc) * 10;
               if (frac_cnt != 0) dm += frac_acc / ten_pow(frac_cnt - 1);
               if (dm > 999999) dm = 999999;
               alt_dm = minus_seen ? -int'(dm) : int'(dm);
            end
         end
      end
      nmea_clear_field();
      if (field_no < FIELD_INDEX_MAX) field_no++;
   endfunction

   // Closes the sentence; a known kind queues one expected word.
   function automatic void nmea_finish();
      fix_report_type r;
      longint         lat_s, lon_s, alt_s;
      parser_idle = 1'b1;
      if (fix_kind == KIND_NONE) return;
      lat_s       = south_seen ? -longint'(lat_mag) : longint'(lat_mag);
      lon_s       = west_seen ? -longint'(lon_mag) : longint'(lon_mag);
      alt_s       = alt_dm;
      r.kind      = fix_kind;
      r.lat       = lat_s[30:0];
      r.lon       = lon_s[31:0];
      r.pos_valid = lat_given && lon_given && fix_kind != KIND_GST;
      r.alt       = alt_s[20:0];
      r.hhmmss    = utc_time[19:0];
      r.hund      = utc_hund[6:0];
      r.quality   = fix_quality[3:0];
      r.sats      = sat_count[6:0];
      fix_reports.push_back(r);
   endfunction

   function automatic void nmea_detect_kind(input logic [7:0] c);
      logic [7:0] third;
      if (byte_pos == POS_KIND_FIRST) begin
         cand_kind = (c == CHAR_G) ? KIND_GGA : KIND_NONE;
      end else if (byte_pos == POS_KIND_SECOND && cand_kind == KIND_GGA) begin
         if (c == CHAR_G) cand_kind = KIND_GGA;
         else if (c == CHAR_N) cand_kind = KIND_GNS;
         else if (c == CHAR_S) cand_kind = KIND_GST;
         else cand_kind = KIND_NONE;
      end else if (byte_pos == POS_KIND_THIRD && cand_kind != KIND_NONE) begin
         case (cand_kind)
            KIND_GGA: third = CHAR_A;
            KIND_GNS: third = CHAR_S;
            default:  third = CHAR_T;
         endcase
         if (c == third) fix_kind = cand_kind;
      end
   endfunction

   function automatic void nmea_accumulate(input logic [7:0] c);
      int unsigned w;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         if (!point_seen) begin
            w         = whole_acc * 10 + (c - CHAR_ZERO);
            whole_acc = (w > WHOLE_CAP) ? WHOLE_CAP : w;
         end else if (frac_cnt < FRAC_MAX) begin
            frac_acc = frac_acc * 10 + (c - CHAR_ZERO);
            frac_cnt++;
         end
      end else if (c == CHAR_POINT) begin
         point_seen = 1'b1;
      end else if (c == CHAR_MINUS && field_chars == 0) begin
         minus_seen = 1'b1;
      end
      if (field_no == FIELD_LAT_HEMI && c == CHAR_S) south_seen = 1'b1;
      if (field_no == FIELD_LON_HEMI && c == CHAR_W) west_seen = 1'b1;
      if (field_chars < FIELD_CHARS_MAX) field_chars++;
   endfunction

   // Advances the predictor by one accepted byte.
   function automatic void nmea_take_byte(input logic [7:0] c, input bit first, input bit last);
      if (first) begin
         nmea_clear_sentence();
         parser_idle = 1'b0;
      end
      if (parser_idle) return;
      if (byte_pos < MAX_SENTENCE_BYTES) begin
         nmea_detect_kind(c);
         if (c == CHAR_STAR) begin
            nmea_close_field();
            nmea_finish();
            return;
         end else if (c == CHAR_COMMA) begin
            nmea_close_field();
         end else begin
            nmea_accumulate(c);
         end
      end
      if (byte_pos < BYTE_POS_MAX) byte_pos++;
      if (last) begin
         nmea_close_field();
         nmea_finish();
      end
   endfunction

   // ---------------------------------------------------------------- bus processes

   // Result side: random stalls per word, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_hold_request != 0) begin
            rx_wait_left    = rx_hold_request;
            rx_hold_request = 0;
         end else if (rsp_tvalid && rsp_tready && rx_idle_on) begin
            rx_wait_left = $urandom_range(6);
         end
         if (rx_wait_left != 0) begin
            rsp_tready <= 1'b0;
            rx_wait_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Each accepted word is compared with the oldest expected fix report.
   always @(posedge clock) begin
      fix_report_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fix_reports.size() == 0) begin
            $error("result word with none expected, kind %0d", rsp_tuser);
            error_count++;
         end else begin
            r = fix_reports.pop_front();
            check_field("sentence_kind", r.kind, rsp_tuser);
            check_field("latitude_e7", r.lat, $signed(rsp_tdata[30:0]));
            check_field("longitude_e7", r.lon, $signed(rsp_tdata[62:31]));
            check_field("position_valid", r.pos_valid, rsp_tdata[63]);
            check_field("altitude_dm", r.alt, $signed(rsp_tdata[84:64]));
            check_field("time_hhmmss", r.hhmmss, rsp_tdata[104:85]);
            check_field("time_hundredths", r.hund, rsp_tdata[111:105]);
            check_field("fix_quality", r.quality, rsp_tdata[115:112]);
            check_field("satellites", r.sats, rsp_tdata[122:116]);
         end
      end
   end

   // Offers one byte, after a random gap when tx_idle_on is set, and waits until it is taken.
   task automatic send_byte(input logic [7:0] c, input bit first, input bit last);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(6) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      nmea_take_byte(c, first, last);
   endtask

   // Sends the buffered sentence; the first byte is flagged, the final one optionally.
   task automatic send_line(input bit with_last);
      for (int i = 0; i < line_buf.size(); i++)
         send_byte(line_buf[i], i == 0, with_last && i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void add_digits(input int unsigned count);
      repeat (count) line_buf.push_back(8'(CHAR_ZERO + $urandom_range(9)));
   endfunction

   task automatic send_text(input string s, input bit with_last);
      line_buf.delete();
      add_text(s);
      send_line(with_last);
   endtask

   // Pause until every expected word has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (fix_reports.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // Bytes before any first byte are ignored, as are bytes after the star.
   task automatic test_idle_bytes();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      line_buf.delete();
      add_text("GGA,1");
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      foreach (line_buf[i]) send_byte(line_buf[i], 1'b0, i == 2);
      line_buf.delete();
      send_text("$GPGGA,123519.25,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n",
                1'b1);
      send_text("x,*12", 1'b1);
      wait_drained();
   endtask

   // The GNS and GST kinds, unknown kinds and near misses in the type letters.
   task automatic test_known_kinds();
      send_text("$GNGNS,014035.00,4332.69262,S,17235.48549,W,RR,13,0.9,25.63,11.24,,*70\r\n",
                1'b1);
      send_text("$GPGST,172814.0,0.006,0.023,0.020,273.6,0.023,0.020,0.031*6A\r\n", 1'b1);
      send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n",
                1'b1);
      send_text("$GPGGX,1,2,N,3,E*00", 1'b1);
      send_text("$GPGSA,A,3,04,05,,09*00", 1'b1);
      send_text("$GPXGA,1,2,N,3,E*00", 1'b1);
      send_text("$GLGNA,1,2,N,3,E,1,2*00", 1'b1);
      wait_drained();
   endtask

   // Largest values, overlong fields, repeated hemisphere letters and signed altitude.
   task automatic test_saturation();
      tx_idle_on = 1'b0;
      send_text("$GPGGA,235959.99,8959.99999,S,17959.99999,W,9,99,0.5,-99999.9,M*00", 1'b1);
      send_text("$GPGGA,1234567.5,99999.9999999,SS,123456789,WW,15,150,,123456.78,M*", 1'b1);
      send_text("$GNGNS,1.5,0000.0,N,00000.0,E,7,100,1,-9999999.9,M*1", 1'b1);
      send_text("$GPGGA,12-3.4-5,4807.0-3,N,01131,E,1x,0.8,,-1.23,-M,9*", 1'b1);
      send_text("$GPGST,999999999.12345,4807.038,S,01131.000,W,9,12,1,100.0*33", 1'b1);
      tx_idle_on = 1'b1;
      wait_drained();
   endtask

   // Empty position fields, and sentences that end before later fields.
   task automatic test_missing_fields();
      send_text("$GPGGA,120000,,N,00000.000,E,1,04,,0,M*", 1'b1);
      send_text("$GNGNS,120000,0000.000,N,,W,AA,04,,0.5*", 1'b1);
      send_text("$GPGGA,120000.5,4807", 1'b1);
      send_text("$GPGGA", 1'b1);
      wait_drained();
   endtask

   // Buffers past the parsed length; field and position counters saturate.
   task automatic test_long_buffer();
      line_buf.delete();
      add_text("$GPGGA");
      repeat (40) line_buf.push_back(CHAR_COMMA);
      while (line_buf.size() < 140) add_text("7");
      send_line(1'b1);
      add_text("$GPGGA,1,1,N,1,E,1,1,,1");
      while (line_buf.size() < 110) add_text("2");
      add_text("*12,3,*");
      send_line(1'b1);
      wait_drained();
   endtask

   // A first byte in the middle of an open sentence restarts the parse.
   task automatic test_restart();
      send_text("$GPGGA,111111,2233.4,S,0", 1'b0);
      send_text("$GPGNS,010203.4,1122.33,N,01122.33,E,,05*11\r\n", 1'b1);
      line_buf.delete();
      add_text("$GPGGA,10");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h00);
      add_text("20,4807.5,N,01131.5,E,2,3");
      line_buf.push_back(8'hAA);
      line_buf.push_back(8'h55);
      add_text(",*");
      send_line(1'b1);
      wait_drained();
   endtask

   // The receiver holds off while short sentences keep coming, then everything drains.
   task automatic test_backpressure();
      tx_idle_on      = 1'b0;
      rx_hold_request = 300;
      repeat (14) send_text("$GPGGA,1*", 1'b0);
      wait_drained();
      tx_idle_on = 1'b1;
   endtask

   // One random field's text; sometimes empty, sometimes overlong or noisy.
   task automatic add_random_field(input int k);
      if ($urandom_range(11) == 0) return;
      case (k)
         1: begin
            add_digits(($urandom_range(15) == 0) ? 9 : 6);
            if ($urandom_range(1)) begin
               add_text(".");
               add_digits($urandom_range(6));
            end
         end
         2, 4: begin
            add_digits(($urandom_range(9) == 0) ? $urandom_range(1, 10) : 4 + (k == 4));
            if ($urandom_range(3) != 0) begin
               add_text(".");
               add_digits($urandom_range(7));
            end
         end
         3: begin
            case ($urandom_range(3))
               0: add_text("N");
               1: add_text("S");
               2: add_text("SS");
               default: add_text("NS");
            endcase
         end
         5: begin
            case ($urandom_range(3))
               0: add_text("E");
               1: add_text("W");
               2: add_text("WW");
               default: add_text("EW");
            endcase
         end
         6: add_digits($urandom_range(1, 2));
         7: add_digits($urandom_range(1, 3));
         9: begin
            if ($urandom_range(2) == 0) add_text("-");
            add_digits($urandom_range(1, 8));
            if ($urandom_range(3) != 0) begin
               add_text(".");
               add_digits($urandom_range(4));
            end
         end
         default: begin
            add_digits($urandom_range(3));
            if ($urandom_range(3) == 0) add_text(".M");
         end
      endcase
      if ($urandom_range(15) == 0) line_buf.push_back(8'($urandom_range(255)));
   endtask

   // Mostly well-formed sentences with random content; some unknown, cut short or noisy.
   task automatic send_random_sentence();
      int unsigned pick, n_fields;
      line_buf.delete();
      add_text("$");
      case ($urandom_range(4))
         0, 1: add_text("GP");
         2:    add_text("GN");
         3:    add_text("GL");
         default: begin
            line_buf.push_back(8'(CHAR_A + $urandom_range(25)));
            line_buf.push_back(8'(CHAR_A + $urandom_range(25)));
         end
      endcase
      pick = $urandom_range(11);
      case (pick)
         0, 1, 2, 3: add_text("GGA");
         4, 5:       add_text("GNS");
         6, 7:       add_text("GST");
         8:          add_text("RMC");
         9:          add_text("GSA");
         10:         add_text("GNA");
         default:    repeat (3) line_buf.push_back(8'($urandom_range(255)));
      endcase
      n_fields = $urandom_range(1, 15);
      for (int k = 1; k <= n_fields; k++) begin
         line_buf.push_back(CHAR_COMMA);
         add_random_field(k);
      end
      pick = $urandom_range(9);
      if (pick <= 5) begin
         add_text("*");
         add_digits(2);
         add_text("\r\n");
         send_line(1'b1);
      end else if (pick <= 7) begin
         send_line(1'b1);
      end else if (pick == 8) begin
         send_line(1'b0);
      end else begin
         add_text("*");
         send_line(1'b1);
      end
   endtask

   // Random sentences fill the run up to its byte budget.
   task automatic test_random_sentences();
      while (bytes_sent < 1750) begin
         // Stretches with and without idling on each side.
         tx_idle_on = $urandom_range(2) != 0;
         rx_idle_on = $urandom_range(2) != 0;
         send_random_sentence();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      nmea_clear_sentence();
      parser_idle = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_bytes();
      test_known_kinds();
      test_saturation();
      test_missing_fields();
      test_long_buffer();
      test_restart();
      test_backpressure();
      test_random_sentences();
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #8ms;
      $display("status: fail");
      $finish;
   end

endmodule
